>>> sv/wpfm_pkg.sv
// ============================================================================
// wpfm_pkg: shared types and constants of the windowed pulse flow meter
// Operation codes, register indexes, field widths and the structs that
// travel between the front end, command queue, back end and divider.
// ============================================================================
`default_nettype none

package wpfm_pkg;

    // Field widths
    localparam int OP_W        = 2;
    localparam int CH_FIELD_W  = 2;
    localparam int FLOW_W      = 24;
    localparam int K_W         = 24;
    localparam int TIME_W      = 32;
    localparam int LIVE_W      = 4;    // holds a channel count up to 15
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 32;
    localparam int OUT_PAD     = OUT_TDATA_W - FLOW_W - 1;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int ACT_W       = 2;
    localparam logic [ACT_W-1:0] ACT_RESET = 2'd3;
    localparam int K_REGS      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_K0     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K1     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_K2     = 2'd3;

    // Metering constants
    localparam int NUM_CHANNELS_DEF = 3;
    localparam logic [TIME_W-1:0] WINDOW_MS   = 32'd1000;
    localparam logic [15:0]       PULSE_SCALE = 16'd60000;  // ms per minute
    localparam int FRAC_SHIFT = 16;     // 16.8 result from 16.8 k

    // Divider widths
    localparam int P60_W = TIME_W + 16;
    localparam int NUM_W = P60_W + FRAC_SHIFT;
    localparam int DEN_W = TIME_W + K_W;
    localparam int QUO_W = FLOW_W;

    // Command queue
    localparam int QDEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 2'd0,
        OP_PULSE = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [CH_FIELD_W-1:0] channel;
        logic                  ok;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [QUO_W-1:0] quot;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> sv/windowed_pulse_flow_meter.sv
// ============================================================================
// windowed_pulse_flow_meter: pulse-frequency flow meter, 1 s windows
// Counts sensor pulses per channel and latches gallons per minute in
// 16.8 fixed point each time a channel's window closes.
// ============================================================================
//
// Usage:
//   s_ channel: one transaction per command (tick, pulse, read, clear).
//   m_ channel: exactly one result transaction per command, in order.
//   cfg channel: register writes, always ready; write only while idle.
// Path: pulse, read and clear pass the front register, the queue, the
//   sequencer's exec and out states and the output register. A tick also
//   scans each live channel and, for each channel whose window closes,
//   runs a multiply state, a start state and the 25-step serial divider.
//   A channel with zero k latches zero without the divider.
// Throughput: set by the back-end sequencer, which runs one command at a
//   time; the front register and a two-entry command queue keep accepting
//   meanwhile, and the output register holds a result while the next one
//   is worked on.
// Reset: aresetn is synchronous, active low; clears time, pulse counts,
//   windows, latched flows and sets active_channels to 3, k to zero.
// Stall: if m_tready stays low the result holds, the queue fills and
//   s_tready drops; nothing is lost.
// ============================================================================
`default_nettype none

module windowed_pulse_flow_meter #(
    parameter int NUM_CHANNELS = wpfm_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // input commands
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [wpfm_pkg::IN_TDATA_W-1:0]  s_tdata,  // [1:0] op, [3:2] channel
    // results
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [wpfm_pkg::OUT_TDATA_W-1:0]      m_tdata,  // [23:0] flow_rate, [24] channel_ok
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wpfm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wpfm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import wpfm_pkg::*;

    logic [ACT_W-1:0]            active_reg;
    logic [K_REGS-1:0][K_W-1:0]  k_regs_reg;

    logic        push_valid;
    logic        push_ready;
    cmd_t        push_cmd;
    logic        pop_valid;
    logic        pop_ready;
    cmd_t        pop_cmd;
    fifo_stat_t  q_stat;
    div_req_t    div_req;
    div_rsp_t    div_rsp;

    // register file: always ready, one write per transaction
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACT_RESET;
            k_regs_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ACTIVE: active_reg    <= cfg_data[ACT_W-1:0];
                CFG_K0:     k_regs_reg[0] <= cfg_data[K_W-1:0];
                CFG_K1:     k_regs_reg[1] <= cfg_data[K_W-1:0];
                CFG_K2:     k_regs_reg[2] <= cfg_data[K_W-1:0];
                default: ;
            endcase
        end
    end

    // front: accept and classify
    wpfm_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .active     (active_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // decoupling queue
    wpfm_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .stat       (q_stat)
    );

    // back: execute, close windows, drive results
    wpfm_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .active    (active_reg),
        .k_regs    (k_regs_reg),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // shared serial divider
    wpfm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

`ifndef SYNTHESIS
    // an inactive or out-of-range channel never reports flow
    a_ok_gates_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[FLOW_W] |-> m_tdata[FLOW_W-1:0] == '0)
        else $error("flow reported without channel_ok");

    // the sequencer never restarts a running division
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // a division result follows a busy divider
    a_div_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> $past(div_rsp.busy))
        else $error("divider done without running");

    // when the queue is full and the front holds a command, input stalls
    a_queue_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.full && push_valid |-> !s_tready)
        else $error("input accepted with queue and front full");
`endif

endmodule

`default_nettype wire

>>> sv/wpfm_front.sv
// ============================================================================
// wpfm_front: input stage
// Accepts input transactions, decodes the op and checks the channel
// against the live channel count, then hands the command to the queue.
// ============================================================================
`default_nettype none

module wpfm_front #(
    parameter int NUM_CHANNELS = wpfm_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [wpfm_pkg::IN_TDATA_W-1:0] s_tdata,  // op, channel
    input  wire logic [wpfm_pkg::ACT_W-1:0]     active,
    output logic                                push_valid,
    input  wire logic                           push_ready,
    output wpfm_pkg::cmd_t                      push_cmd
);
    import wpfm_pkg::*;

    logic                  hold_valid_reg;
    cmd_t                  cmd_reg;
    logic [LIVE_W-1:0]     live;
    logic [CH_FIELD_W-1:0] ch;
    cmd_t                  cmd_next;

    assign live = (LIVE_W'(active) > LIVE_W'(NUM_CHANNELS)) ?
                  LIVE_W'(NUM_CHANNELS) : LIVE_W'(active);
    assign ch   = s_tdata[OP_W +: CH_FIELD_W];

    always_comb begin
        cmd_next.op      = op_t'(s_tdata[OP_W-1:0]);
        cmd_next.channel = ch;
        cmd_next.ok      = LIVE_W'(ch) < live;
    end

    assign s_tready   = !hold_valid_reg || push_ready;
    assign push_valid = hold_valid_reg;
    assign push_cmd   = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            hold_valid_reg <= 1'b1;
        end else if (push_ready) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/wpfm_cmd_fifo.sv
// ============================================================================
// wpfm_cmd_fifo: command queue
// Short queue of decoded commands between the front end and the back end.
// ============================================================================
`default_nettype none

module wpfm_cmd_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire wpfm_pkg::cmd_t push_cmd,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output wpfm_pkg::cmd_t      pop_cmd,
    output wpfm_pkg::fifo_stat_t stat
);
    import wpfm_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    cmd_t             mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign stat.full  = count_reg == CNT_W'(QDEPTH);
    assign stat.empty = count_reg == '0;
    assign push_ready = !stat.full;
    assign pop_valid  = !stat.empty;
    assign pop_cmd    = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

>>> sv/wpfm_div.sv
// ============================================================================
// wpfm_div: serial flow divider
// Restoring division, one quotient bit per cycle. The first step checks
// for overflow of the 24-bit quotient and saturates.
// ============================================================================
`default_nettype none

module wpfm_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire wpfm_pkg::div_req_t req,
    output wpfm_pkg::div_rsp_t      rsp
);
    import wpfm_pkg::*;

    localparam int D_W   = DEN_W + QUO_W;
    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [D_W-1:0]   dsr_reg;
    logic [QUO_W-1:0] quot_reg;
    logic             ge;

    // remainder against the shifted divisor
    assign ge = {{(D_W - NUM_W){1'b0}}, rem_reg} >= dsr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if ((ge && cnt_reg == CNT_W'(QUO_W)) || cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg  <= req.num;
            dsr_reg  <= {req.den, {QUO_W{1'b0}}};
            cnt_reg  <= CNT_W'(QUO_W);
            quot_reg <= '0;
        end else if (busy_reg) begin
            if (ge && cnt_reg == CNT_W'(QUO_W)) begin
                quot_reg <= '1;            // quotient overflows: saturate
            end else begin
                if (ge) begin
                    rem_reg <= rem_reg - dsr_reg[NUM_W-1:0];
                end
                quot_reg <= {quot_reg[QUO_W-2:0], ge};
                dsr_reg  <= dsr_reg >> 1;
                cnt_reg  <= cnt_reg - 1'b1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

`default_nettype wire

>>> sv/wpfm_back.sv
// ============================================================================
// wpfm_back: command execution
// Sequencer that runs queued commands against the channel state, closes
// windows on ticks through the shared divider and registers the result.
// ============================================================================
`default_nettype none

module wpfm_back #(
    parameter int NUM_CHANNELS = wpfm_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             pop_valid,
    output logic                                  pop_ready,
    input  wire wpfm_pkg::cmd_t                   pop_cmd,
    input  wire logic [wpfm_pkg::ACT_W-1:0]       active,
    input  wire logic [wpfm_pkg::K_REGS-1:0][wpfm_pkg::K_W-1:0] k_regs,
    output wpfm_pkg::div_req_t                    div_req,
    input  wire wpfm_pkg::div_rsp_t               div_rsp,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [wpfm_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import wpfm_pkg::*;

    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int IDX_W = $clog2(NUM_CHANNELS + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_EXEC  = 7'b0000010,
        ST_SCAN  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_START = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    cmd_t                cmd_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [TIME_W-1:0]   pt_reg [NUM_CHANNELS];
    logic [TIME_W-1:0]   ws_reg [NUM_CHANNELS];
    logic [FLOW_W-1:0]   fv_reg [NUM_CHANNELS];
    logic [TIME_W-1:0]   p_reg;
    logic [TIME_W-1:0]   d_reg;
    logic [K_W-1:0]      k_op_reg;
    logic [P60_W-1:0]    p60_reg;
    logic [DEN_W-1:0]    dk_reg;
    logic [FLOW_W-1:0]   res_flow_reg;
    logic                res_ok_reg;
    logic                out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [LIVE_W-1:0]   live;
    logic [CH_W-1:0]     sel;
    logic                in_range;
    logic [TIME_W-1:0]   dt;
    logic                win_done;
    logic [K_W-1:0]      k_sel;
    logic                out_free;

    assign live     = (LIVE_W'(active) > LIVE_W'(NUM_CHANNELS)) ?
                      LIVE_W'(NUM_CHANNELS) : LIVE_W'(active);
    assign sel      = idx_reg[CH_W-1:0];
    assign in_range = LIVE_W'(idx_reg) < live;
    assign dt       = now_reg - ws_reg[sel];
    assign win_done = dt >= WINDOW_MS;
    assign k_sel    = (LIVE_W'(idx_reg) < LIVE_W'(K_REGS)) ? k_regs[2'(idx_reg)] : '0;
    assign out_free = !out_valid_reg || m_tready;

    assign pop_ready     = state_reg == ST_IDLE;
    assign div_req.start = state_reg == ST_START;
    assign div_req.num   = {p60_reg, {FRAC_SHIFT{1'b0}}};
    assign div_req.den   = dk_reg;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (pop_valid) state_next = ST_EXEC;
            ST_EXEC:  state_next = (cmd_reg.op == OP_TICK) ? ST_SCAN : ST_OUT;
            ST_SCAN: begin
                if (!in_range) begin
                    state_next = ST_OUT;
                end else if (win_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = (k_op_reg == '0) ? ST_SCAN : ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:   if (div_rsp.done) state_next = ST_SCAN;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control and channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            now_reg   <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                pt_reg[i] <= '0;
                ws_reg[i] <= '0;
                fv_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_EXEC: begin
                    unique case (cmd_reg.op)
                        OP_TICK:  now_reg <= now_reg + 1'b1;
                        OP_PULSE: if (cmd_reg.ok) pt_reg[sel] <= pt_reg[sel] + 1'b1;
                        OP_READ:  ;
                        OP_CLEAR: begin
                            for (int i = 0; i < NUM_CHANNELS; i++) begin
                                if (LIVE_W'(i) < live) pt_reg[i] <= '0;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_SCAN: begin
                    if (in_range && win_done) begin
                        pt_reg[sel] <= '0;
                        ws_reg[sel] <= now_reg;
                    end
                end
                ST_MUL: if (k_op_reg == '0) fv_reg[sel] <= '0;
                ST_DIV: if (div_rsp.done) fv_reg[sel] <= div_rsp.quot;
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    cmd_reg <= pop_cmd;
                    idx_reg <= (pop_cmd.op != OP_TICK && pop_cmd.ok) ?
                               IDX_W'(pop_cmd.channel) : '0;
                end
            end
            ST_EXEC: begin
                res_ok_reg   <= cmd_reg.ok;
                res_flow_reg <= (cmd_reg.op == OP_READ && cmd_reg.ok) ? fv_reg[sel] : '0;
            end
            ST_SCAN: begin
                if (in_range) begin
                    if (win_done) begin
                        p_reg    <= pt_reg[sel];
                        d_reg    <= dt;
                        k_op_reg <= k_sel;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
            end
            ST_MUL: begin
                p60_reg <= P60_W'(p_reg) * P60_W'(PULSE_SCALE);
                dk_reg  <= DEN_W'(d_reg) * DEN_W'(k_op_reg);
                if (k_op_reg == '0) idx_reg <= idx_reg + 1'b1;
            end
            ST_DIV: if (div_rsp.done) idx_reg <= idx_reg + 1'b1;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && out_free) begin
            out_data_reg <= {{OUT_PAD{1'b0}}, res_ok_reg, res_flow_reg};
        end
    end

endmodule

`default_nettype wire

>>> sim/flow_meter_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// flow_meter_checker: result predictor and comparator for the flow meter
// Watches the command, result and register channels, keeps its own copy of
// the meter state, and compares every result transaction in order.
// ============================================================================

module flow_meter_checker
    import wpfm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [1:0] op, [3:2] channel
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,   // [23:0] flow_rate, [24] channel_ok
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          mismatches,
    output int                          awaiting,
    output int                          windows_closed,
    output int                          flow_reads,
    output int                          saturated_reads
);

    localparam int                meter_ch  = NUM_CHANNELS_DEF;
    localparam logic [TIME_W-1:0] WINDOW_LEN = 32'd1000;
    localparam logic [FLOW_W-1:0] FLOW_SAT  = '1;

    typedef struct packed {
        logic              channel_ok;
        logic [FLOW_W-1:0] flow_rate;
    } meter_result_t;

    meter_result_t     expected_results[$];
    int                results_seen;

    logic [ACT_W-1:0]  active_reg;
    logic [K_W-1:0]    k_reg [K_REGS];
    logic [TIME_W-1:0] clock_ms;
    logic [TIME_W-1:0] pulse_count [meter_ch];
    logic [TIME_W-1:0] window_open [meter_ch];
    logic [FLOW_W-1:0] latched_gpm [meter_ch];

    // 16.8 gallons per minute from pulses over dt ms with 16.8 pulses/gallon
    function automatic logic [FLOW_W-1:0] gpm_from_pulses(logic [TIME_W-1:0] pulses,
                                                          logic [TIME_W-1:0] dt,
                                                          logic [K_W-1:0] k);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        if (k == '0 || dt == '0) return '0;
        num = 64'(pulses) * 64'd60000 * 64'd65536;
        den = 64'(dt) * 64'(k);
        q   = num / den;
        return (q > 64'(FLOW_SAT)) ? FLOW_SAT : q[FLOW_W-1:0];
    endfunction

    function automatic int unsigned live_channels();
        return (int'(active_reg) > meter_ch) ? meter_ch : int'(active_reg);
    endfunction

    task automatic meter_step(input op_t op, input logic [CH_FIELD_W-1:0] ch,
                              output meter_result_t r);
        int unsigned       n;
        logic [TIME_W-1:0] dt;
        logic [K_W-1:0]    k;
        n = live_channels();
        r.channel_ok = (ch < n);
        r.flow_rate  = '0;
        case (op)
            OP_TICK: begin
                clock_ms = clock_ms + 1'b1;
                for (int i = 0; i < n; i++) begin
                    dt = clock_ms - window_open[i];
                    if (dt >= WINDOW_LEN) begin
                        k = (i < K_REGS) ? k_reg[i] : '0;
                        latched_gpm[i] = gpm_from_pulses(pulse_count[i], dt, k);
                        pulse_count[i] = '0;
                        window_open[i] = clock_ms;
                        windows_closed++;
                    end
                end
            end
            OP_PULSE: begin
                if (r.channel_ok) pulse_count[ch] = pulse_count[ch] + 1'b1;
            end
            OP_READ: begin
                if (r.channel_ok) begin
                    r.flow_rate = latched_gpm[ch];
                    if (r.flow_rate != '0) flow_reads++;
                    if (r.flow_rate == FLOW_SAT) saturated_reads++;
                end
            end
            default: begin
                // clear touches live channels only, windows stay open
                for (int i = 0; i < n; i++) pulse_count[i] = '0;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch at result %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, results_seen, what, got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        meter_result_t got;
        meter_result_t want;
        if (!aresetn) begin
            expected_results.delete();
            active_reg = ACT_RESET;
            clock_ms   = '0;
            for (int i = 0; i < K_REGS; i++) k_reg[i] = '0;
            for (int i = 0; i < meter_ch; i++) begin
                pulse_count[i] = '0;
                window_open[i] = '0;
                latched_gpm[i] = '0;
            end
            awaiting = 0;
        end else begin
            // results first: a command accepted this edge cannot answer yet
            if (m_tvalid && m_tready) begin
                got = m_tdata[FLOW_W:0];
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 32'(got), '0);
                end else begin
                    want = expected_results.pop_front();
                    if (got.flow_rate !== want.flow_rate)
                        report_mismatch("flow_rate", 32'(got.flow_rate), 32'(want.flow_rate));
                    if (got.channel_ok !== want.channel_ok)
                        report_mismatch("channel_ok", 32'(got.channel_ok),
                                        32'(want.channel_ok));
                end
                results_seen++;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ACTIVE: active_reg = cfg_data[ACT_W-1:0];
                    CFG_K0:     k_reg[0]   = cfg_data;
                    CFG_K1:     k_reg[1]   = cfg_data;
                    default:    k_reg[2]   = cfg_data;
                endcase
            end
            if (s_tvalid && s_tready) begin
                meter_step(op_t'(s_tdata[OP_W-1:0]), s_tdata[OP_W +: CH_FIELD_W], want);
                expected_results.push_back(want);
            end
            awaiting = expected_results.size();
        end
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: stimulus and verdict for the windowed pulse flow meter
// Drives tick, pulse, read and clear commands in bursts through a series of
// register settings chosen to close windows under zero, tiny and moderate k,
// frozen and resumed channels and a saturating pulse load. The checker
// beside the block predicts and compares each result transaction.
// ============================================================================

module tb_top;
    import wpfm_pkg::*;

    localparam int          PERIOD       = 12;
    localparam int          RESET_CYCLES = 9;
    localparam int          SETTLE_GAP   = 4;
    // Idle time after the last result is back, before the verdict.
    localparam int          DRAIN_CYCLES = 200;
    // Slowest correct run: ~1.8k commands, each with its time in the block plus
    // the sender gap plus the receiver stall. The limit leaves a wide margin.
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;      // [1:0] op, [3:2] channel
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;             // [23:0] flow_rate, [24] channel_ok
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int                     mismatches;
    int                     awaiting;
    int                     windows_closed;
    int                     flow_reads;
    int                     saturated_reads;

    int unsigned            commands_sent = 0;
    int unsigned            ticks_sent    = 0;   // mirrors the block's ms clock
    int unsigned            burst_left    = 0;
    int unsigned            cycle_count   = 0;
    int unsigned            stall_count   = 0;
    logic [1:0]             stall_mode    = 2'd0;

    always #(PERIOD / 2) aclk = ~aclk;

    windowed_pulse_flow_meter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    flow_meter_checker u_flow_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .awaiting        (awaiting),
        .windows_closed  (windows_closed),
        .flow_reads      (flow_reads),
        .saturated_reads (saturated_reads)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, awaiting);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result-side back-pressure, in one of four modes drawn at random:
    // always ready, random drops, a short periodic stall, or long stalls
    // that fill the command queue and push back on s_tready.
    always @(negedge aclk) begin
        if (stall_count % 400 == 0) stall_mode = 2'($urandom_range(0, 3));
        stall_count++;
        case (stall_mode)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 9) < 7);
            2'd2:    m_tready <= (stall_count % 5) >= 2;
            default: m_tready <= (stall_count % 48) >= 28;
        endcase
    end

    // One command transaction. Commands go out in bursts; between bursts
    // the sender idles a random number of cycles with junk on tdata, and
    // a quarter of bursts follow the last with no gap at all.
    task automatic send_cmd(input op_t op, input logic [CH_FIELD_W-1:0] ch);
        int unsigned gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= IN_TDATA_W'($urandom);
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - OP_W - CH_FIELD_W){1'b0}}, ch, op};
        do @(posedge aclk); while (!s_tready);
        commands_sent++;
        if (op == OP_TICK) ticks_sent++;
    endtask

    // Caller sits at a falling edge; leaves cfg_valid high for the next write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
    endtask

    // Registers change only with the block idle: every result back first.
    task automatic reconfigure(input logic [ACT_W-1:0] act, input logic [K_W-1:0] k0,
                               input logic [K_W-1:0] k1, input logic [K_W-1:0] k2);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaiting != 0) @(negedge aclk);
        repeat (SETTLE_GAP) @(negedge aclk);
        write_reg(CFG_ACTIVE, CFG_DATA_W'(act));
        write_reg(CFG_K0, k0);
        write_reg(CFG_K1, k1);
        write_reg(CFG_K2, k2);
        cfg_valid <= 1'b0;
        burst_left = 0;
    endtask

    // Random commands until the ms clock reaches until_ms. Weights set the
    // op mix; hot_pct percent of commands go to hot_ch, the rest to any
    // channel including the one beyond the sensors.
    task automatic run_phase(input int unsigned until_ms,
                             input int unsigned w_tick, w_pulse, w_read, w_clear,
                             input logic [CH_FIELD_W-1:0] hot_ch,
                             input int unsigned hot_pct);
        int unsigned           pick;
        op_t                   op;
        logic [CH_FIELD_W-1:0] ch;
        while (ticks_sent < until_ms) begin
            pick = $urandom_range(0, w_tick + w_pulse + w_read + w_clear - 1);
            if (pick < w_tick)                          op = OP_TICK;
            else if (pick < w_tick + w_pulse)           op = OP_PULSE;
            else if (pick < w_tick + w_pulse + w_read)  op = OP_READ;
            else                                        op = OP_CLEAR;
            ch = ($urandom_range(0, 99) < hot_pct) ? hot_ch : CH_FIELD_W'($urandom);
            send_cmd(op, ch);
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed ---
        // Reset settings: three live channels, every k zero.
        send_cmd(OP_READ,  2'd0);
        send_cmd(OP_READ,  2'd3);     // channel past the sensors
        send_cmd(OP_PULSE, 2'd3);     // ignored
        send_cmd(OP_PULSE, 2'd0);
        send_cmd(OP_TICK,  2'd1);
        send_cmd(OP_CLEAR, 2'd2);

        // Two live channels: channel 2 goes inactive, k at its extremes.
        reconfigure(2'd2, 24'hFFFFFF, 24'h000001, 24'h000100);
        send_cmd(OP_PULSE, 2'd0);
        send_cmd(OP_PULSE, 2'd1);
        send_cmd(OP_PULSE, 2'd2);     // inactive, dropped
        send_cmd(OP_PULSE, 2'd3);
        send_cmd(OP_READ,  2'd0);
        send_cmd(OP_READ,  2'd1);
        send_cmd(OP_READ,  2'd2);     // inactive reads as zero, not ok
        send_cmd(OP_READ,  2'd3);
        send_cmd(OP_CLEAR, 2'd0);
        send_cmd(OP_TICK,  2'd3);
        send_cmd(OP_TICK,  2'd0);
        send_cmd(OP_PULSE, 2'd1);
        send_cmd(OP_READ,  2'd1);
        send_cmd(OP_TICK,  2'd2);
        send_cmd(OP_READ,  2'd2);

        // --- random phases ---
        // Every window opened at 0 ms, so channels 0 and 1 close together at
        // 1000 ms; k is sampled when the window closes.

        // All live: pulses build up on every channel, channel 2 included.
        reconfigure(2'd3, 24'h000001, K_W'($urandom_range(128, 1024)), 24'h000100);
        run_phase(400, 60, 30, 9, 1, 2'd0, 30);

        // Channel 2 frozen: clears leave its count alone, its window stays open.
        reconfigure(2'd2, 24'h000001, K_W'($urandom_range(128, 1024)), 24'h000100);
        run_phase(990, 85, 10, 4, 1, 2'd0, 30);

        // Window close at 1000 ms: k of 1 saturates channel 0, zero k on
        // channel 1 latches zero. Reads follow.
        reconfigure(2'd2, 24'h000001, 24'h000000, K_W'($urandom));
        run_phase(1060, 45, 20, 30, 5, 2'd0, 40);

        // Channel 2 resumes and closes at once with a long elapsed time.
        reconfigure(2'd3, 24'h000000, 24'hFFFFFF, K_W'($urandom_range(1, 255)));
        run_phase(ticks_sent + 60, 45, 20, 30, 5, 2'd2, 40);

        // Nothing live: every command answers not ok, ticks close nothing.
        reconfigure(2'd0, K_W'($urandom), K_W'($urandom), K_W'($urandom));
        run_phase(ticks_sent + 40, 25, 40, 30, 5, 2'd0, 0);

        // --- drain and verdict ---
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (awaiting != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d commands spanning %0d ms across seven register settings.",
                 commands_sent, ticks_sent);
        $display("Windows closed %0d, nonzero flow reads %0d, saturated reads %0d, mismatches %0d.",
                 windows_closed, flow_reads, saturated_reads, mismatches);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
